>>> rtl/core/eptw_pkg.sv
// Package for the four-level table walker: sizes, entry formats, codes and the microcode ROM.
// Depends on nothing; the walker and its checker import it.
package eptw_pkg;

	// Table store geometry.
	localparam int TABLE_PAGES  = 64;
	localparam int IDX_W        = 9;
	localparam int PAGE_W       = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
	localparam int NFP_W        = $clog2(TABLE_PAGES + 1);
	localparam int ADDR_W       = PAGE_W + IDX_W;
	localparam int ENTRIES      = TABLE_PAGES * (1 << IDX_W);
	localparam int ENTRY_W      = 64;

	// Field widths.
	localparam int GPA_W        = 48;
	localparam int HPA_W        = 52;
	localparam int OFS_W        = 12;

	// Entry low bits: pointer entries carry the access bits, leaves add write-back type.
	localparam logic [OFS_W-1:0] PTR_FLAGS  = 12'h007;
	localparam logic [OFS_W-1:0] LEAF_FLAGS = 12'h037;
	localparam logic [1:0]       LEAF_LEVEL = 2'd3;

	typedef logic [ENTRY_W-1:0] entry_t;

	typedef enum logic [1:0] {
		CMD_XLATE = 2'd0,
		CMD_MAP   = 2'd1,
		CMD_UNMAP = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK              = 3'd0,
		ST_NO_ENTRY        = 3'd1,
		ST_NO_MEMORY       = 3'd2,
		ST_WOULD_OVERWRITE = 3'd3,
		ST_NOT_MAPPED      = 3'd4
	} status_t;

	// Datapath action selected by one control word.
	typedef enum logic [3:0] {
		A_NONE,
		A_CLEAR,
		A_LOAD,
		A_READ,
		A_SET,
		A_ALLOC,
		A_DESC,
		A_UNMAP,
		A_XHIT,
		A_LEAFWR,
		A_EMIT
	} act_t;

	// Jump condition; the sequencer jumps to the target when it holds, else steps on.
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_IN,
		C_BAD_CMD,
		C_LEAF,
		C_PRESENT,
		C_NO_CREATE,
		C_NO_MEM,
		C_IS_XLATE,
		C_IS_MAP,
		C_OVR_BLOCK,
		C_OUT_FULL,
		C_CLR_BUSY
	} cond_t;

	typedef logic [4:0] upc_t;

	typedef struct packed {
		act_t    act;
		status_t st;
		cond_t   cond;
		upc_t    target;
	} ucode_t;

	// Program addresses.
	localparam upc_t U_CLEAR  = 5'd0;
	localparam upc_t U_IDLE   = 5'd1;
	localparam upc_t U_CMD    = 5'd2;
	localparam upc_t U_READ   = 5'd3;
	localparam upc_t U_EVAL   = 5'd4;
	localparam upc_t U_PRES   = 5'd5;
	localparam upc_t U_CREATE = 5'd6;
	localparam upc_t U_ROOM   = 5'd7;
	localparam upc_t U_ALLOC  = 5'd8;
	localparam upc_t U_DESC   = 5'd9;
	localparam upc_t U_LEAF   = 5'd10;
	localparam upc_t U_KIND   = 5'd11;
	localparam upc_t U_UNMAP  = 5'd12;
	localparam upc_t U_XLATE  = 5'd13;
	localparam upc_t U_XMISS  = 5'd14;
	localparam upc_t U_XHIT   = 5'd15;
	localparam upc_t U_MAP    = 5'd16;
	localparam upc_t U_MAPWR  = 5'd17;
	localparam upc_t U_WOVR   = 5'd18;
	localparam upc_t U_NOENT  = 5'd19;
	localparam upc_t U_NOMEM  = 5'd20;
	localparam upc_t U_DONE   = 5'd21;
	localparam upc_t U_RET    = 5'd22;

	function automatic ucode_t uw(input act_t a, input status_t s, input cond_t c,
			input upc_t t);
		ucode_t w;
		w.act    = a;
		w.st     = s;
		w.cond   = c;
		w.target = t;
		return w;
	endfunction

	function automatic ucode_t ucode_rom(input upc_t pc);
		ucode_t w;
		case (pc)
			U_CLEAR:  w = uw(A_CLEAR,  ST_OK,              C_CLR_BUSY,  U_CLEAR);
			U_IDLE:   w = uw(A_LOAD,   ST_OK,              C_NO_IN,     U_IDLE);
			U_CMD:    w = uw(A_NONE,   ST_OK,              C_BAD_CMD,   U_NOENT);
			U_READ:   w = uw(A_READ,   ST_OK,              C_NEVER,     U_IDLE);
			U_EVAL:   w = uw(A_NONE,   ST_OK,              C_LEAF,      U_LEAF);
			U_PRES:   w = uw(A_NONE,   ST_OK,              C_PRESENT,   U_DESC);
			U_CREATE: w = uw(A_NONE,   ST_OK,              C_NO_CREATE, U_NOENT);
			U_ROOM:   w = uw(A_NONE,   ST_OK,              C_NO_MEM,    U_NOMEM);
			U_ALLOC:  w = uw(A_ALLOC,  ST_OK,              C_ALWAYS,    U_READ);
			U_DESC:   w = uw(A_DESC,   ST_OK,              C_ALWAYS,    U_READ);
			U_LEAF:   w = uw(A_NONE,   ST_OK,              C_IS_XLATE,  U_XLATE);
			U_KIND:   w = uw(A_NONE,   ST_OK,              C_IS_MAP,    U_MAP);
			U_UNMAP:  w = uw(A_UNMAP,  ST_OK,              C_ALWAYS,    U_DONE);
			U_XLATE:  w = uw(A_NONE,   ST_OK,              C_PRESENT,   U_XHIT);
			U_XMISS:  w = uw(A_SET,    ST_NOT_MAPPED,      C_ALWAYS,    U_DONE);
			U_XHIT:   w = uw(A_XHIT,   ST_OK,              C_ALWAYS,    U_DONE);
			U_MAP:    w = uw(A_NONE,   ST_OK,              C_OVR_BLOCK, U_WOVR);
			U_MAPWR:  w = uw(A_LEAFWR, ST_OK,              C_ALWAYS,    U_DONE);
			U_WOVR:   w = uw(A_SET,    ST_WOULD_OVERWRITE, C_ALWAYS,    U_DONE);
			U_NOENT:  w = uw(A_SET,    ST_NO_ENTRY,        C_ALWAYS,    U_DONE);
			U_NOMEM:  w = uw(A_SET,    ST_NO_MEMORY,       C_ALWAYS,    U_DONE);
			U_DONE:   w = uw(A_EMIT,   ST_OK,              C_OUT_FULL,  U_DONE);
			U_RET:    w = uw(A_NONE,   ST_OK,              C_ALWAYS,    U_IDLE);
			default:  w = uw(A_NONE,   ST_OK,              C_ALWAYS,    U_IDLE);
		endcase
		return w;
	endfunction

endpackage

>>> rtl/core/ept_four_level_table_walker.sv
// Four-level radix table walker: a microcoded sequencer over a table store of 64-bit entries.
// Depends on eptw_pkg (sizes, entry formats, status codes, microcode ROM).
//
// Channel   Direction  Handshake                   Payload
// s_axis    in         s_axis_tvalid/s_axis_tready tuser: cmd; tdata: gpa, hpa, create, overwrite
// m_axis    out        m_axis_tvalid/m_axis_tready tuser: status; tdata: result_hpa
//
// After reset is released the block sweeps the whole table store to zero, one entry a cycle;
// no item is accepted during the sweep. The block takes one item at a time. Each level above
// the leaf costs four steps (read, leaf check, presence check, descend); every table page
// allocated on the way adds two steps. The single read port of the store paces the walk, as
// each level waits on its registered data. After the result is registered the sequencer
// passes through U_RET before the next item can be taken.
// The next item is accepted while a finished result still sits in the output register; the
// walk only pauses in its last step until that register is free.
module ept_four_level_table_walker
	import eptw_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [103:0] s_axis_tdata,   // gpa[47:0], hpa[99:48], create[100], overwrite[101], zero
	input  logic [1:0]   s_axis_tuser,   // cmd[1:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [55:0]  m_axis_tdata,   // result_hpa[51:0], zero
	output logic [2:0]   m_axis_tuser    // status[2:0]
);

	// Sequencer state.
	upc_t               upc_q;
	ucode_t             uw_c;
	logic               jump_c;
	logic [ADDR_W-1:0]  clr_q;
	logic [NFP_W-1:0]   nfp_q;

	// Item registers and walk position.
	logic [1:0]         cmd_q;
	logic [GPA_W-1:0]   gpa_q;
	logic [HPA_W-1:0]   hpa_q;
	logic               create_q;
	logic               overwrite_q;
	logic [PAGE_W-1:0]  page_q;
	logic [1:0]         lvl_q;
	status_t            status_q;
	logic [HPA_W-1:0]   res_q;

	// Output register.
	logic               m_valid_q;
	logic [HPA_W-1:0]   m_hpa_q;
	status_t            m_status_q;

	// Table store.
	entry_t             mem [ENTRIES];
	entry_t             rdata_q;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	entry_t             mem_wdata;
	logic [IDX_W-1:0]   idx_c;
	logic [ADDR_W-1:0]  cur_addr;

	logic               s_acc;
	logic               out_free;
	logic               present;
	logic [PAGE_W-1:0]  ptr_page;

	assign uw_c          = ucode_rom(upc_q);
	assign s_axis_tready = (upc_q == U_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign present       = |rdata_q[2:0];

	// A pointer beyond the store is followed to the root, as the table never holds one.
	assign ptr_page = (rdata_q[ENTRY_W-1:OFS_W] < (ENTRY_W-OFS_W)'(TABLE_PAGES)) ?
		rdata_q[OFS_W+PAGE_W-1:OFS_W] : '0;

	// Nine index bits of the guest address for the level being walked.
	always_comb begin
		case (lvl_q)
			2'd0:    idx_c = gpa_q[47:39];
			2'd1:    idx_c = gpa_q[38:30];
			2'd2:    idx_c = gpa_q[29:21];
			default: idx_c = gpa_q[20:12];
		endcase
	end

	assign cur_addr = {page_q, idx_c};

	// Jump condition of the current control word.
	always_comb begin
		case (uw_c.cond)
			C_NEVER:     jump_c = 1'b0;
			C_ALWAYS:    jump_c = 1'b1;
			C_NO_IN:     jump_c = !s_acc;
			C_BAD_CMD:   jump_c = !(cmd_q inside {CMD_XLATE, CMD_MAP, CMD_UNMAP});
			C_LEAF:      jump_c = (lvl_q == LEAF_LEVEL);
			C_PRESENT:   jump_c = present;
			C_NO_CREATE: jump_c = !((cmd_q == CMD_MAP) && create_q);
			C_NO_MEM:    jump_c = (nfp_q == NFP_W'(TABLE_PAGES));
			C_IS_XLATE:  jump_c = (cmd_q == CMD_XLATE);
			C_IS_MAP:    jump_c = (cmd_q == CMD_MAP);
			C_OVR_BLOCK: jump_c = present && !overwrite_q;
			C_OUT_FULL:  jump_c = !out_free;
			C_CLR_BUSY:  jump_c = (clr_q != ADDR_W'(ENTRIES - 1));
			default:     jump_c = 1'b0;
		endcase
	end

	// Store write port: the reset sweep, new pointer entries, leaf writes and unmap clears.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_addr;
		mem_wdata = '0;
		case (uw_c.act)
			A_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			A_ALLOC: begin
				mem_we    = 1'b1;
				mem_wdata = {{(ENTRY_W-OFS_W-NFP_W){1'b0}}, nfp_q, PTR_FLAGS};
			end
			A_LEAFWR: begin
				mem_we    = 1'b1;
				mem_wdata = {{(ENTRY_W-HPA_W){1'b0}}, hpa_q[HPA_W-1:OFS_W], LEAF_FLAGS};
			end
			A_UNMAP: begin
				mem_we    = 1'b1;
			end
			default: begin
				mem_we    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (uw_c.act == A_READ) begin
			rdata_q <= mem[cur_addr];
		end
	end

	// Control state: step counter, sweep counter, page allocator, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q     <= U_CLEAR;
			clr_q     <= '0;
			nfp_q     <= NFP_W'(1);
			m_valid_q <= 1'b0;
		end else begin
			upc_q <= jump_c ? uw_c.target : upc_q + 5'd1;
			if (uw_c.act == A_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (uw_c.act == A_ALLOC) begin
				nfp_q <= nfp_q + NFP_W'(1);
			end
			if (uw_c.act == A_EMIT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (uw_c.act)
			A_LOAD: begin
				if (s_acc) begin
					cmd_q       <= s_axis_tuser;
					gpa_q       <= s_axis_tdata[47:0];
					hpa_q       <= s_axis_tdata[99:48];
					create_q    <= s_axis_tdata[100];
					overwrite_q <= s_axis_tdata[101];
					page_q      <= '0;
					lvl_q       <= 2'd0;
					status_q    <= ST_OK;
					res_q       <= '0;
				end
			end
			A_SET: begin
				status_q <= uw_c.st;
			end
			A_ALLOC: begin
				page_q <= nfp_q[PAGE_W-1:0];
				lvl_q  <= lvl_q + 2'd1;
			end
			A_DESC: begin
				page_q <= ptr_page;
				lvl_q  <= lvl_q + 2'd1;
			end
			A_UNMAP: begin
				res_q <= {rdata_q[HPA_W-1:OFS_W], {OFS_W{1'b0}}};
			end
			A_XHIT: begin
				res_q <= {rdata_q[HPA_W-1:OFS_W], gpa_q[OFS_W-1:0]};
			end
			A_EMIT: begin
				if (out_free) begin
					m_hpa_q    <= res_q;
					m_status_q <= status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'b0, m_hpa_q};
	assign m_axis_tuser  = m_status_q;

endmodule

>>> rtl/core/eptw_checker.sv
// Port-level checker for the table walker, attached by the bind statement at the end.
// Depends on eptw_pkg for the status codes.
module eptw_checker
	import eptw_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [55:0]  m_axis_tdata,
	input  logic [2:0]   m_axis_tuser
);

	// The walker takes one item at a time, so it closes its input right after taking one.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted twice in a row");

	// A result never appears in the cycle right after an item is taken.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
		else $error("result appeared without a walk");

	// Status codes stay within the defined set.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_NO_ENTRY) ||
			(m_axis_tuser == ST_NO_MEMORY) || (m_axis_tuser == ST_WOULD_OVERWRITE) ||
			(m_axis_tuser == ST_NOT_MAPPED))
		else $error("undefined status");

	// Any failed command returns a zero address.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
		else $error("nonzero address with a failing status");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

endmodule

bind ept_four_level_table_walker eptw_checker u_eptw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

>>> sim/tb_top.sv
// Self-checking bench for ept_four_level_table_walker: stream driver, stream monitor and a
// table-walk predictor with its own copy of the table store and page counter.
// Depends on eptw_pkg (sizes, entry flags, command and status codes) and the walker RTL.
`timescale 1ns / 100ps

module tb_top
	import eptw_pkg::*;
();

	// The one command code that the package leaves undefined.
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	// Cycles with no handshake on either side before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 4 * ENTRIES;
	// Length of the long output hold that forces the walker to back up its input.
	localparam int OUT_HOLD_CYCLES = 300;
	// Quiet cycles after the last result, well past the walk latency.
	localparam int TAIL_CYCLES = 60;
	localparam int PAGE_ENTRIES = 1 << IDX_W;

	typedef struct {
		logic [1:0]       cmd;
		logic [GPA_W-1:0] gpa;
		logic [HPA_W-1:0] hpa;
		bit               create;
		bit               ovr;
	} walk_req_t;

	typedef struct {
		status_t          st;
		logic [HPA_W-1:0] hpa;
	} walk_reply_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [103:0] s_axis_tdata = '0;   // gpa[47:0], hpa[99:48], create[100], overwrite[101], zero
	logic [1:0]   s_axis_tuser = '0;   // cmd[1:0]
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [55:0]  m_axis_tdata;        // result_hpa[51:0], zero
	logic [2:0]   m_axis_tuser;        // status[2:0]

	ept_four_level_table_walker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #4 clk = ~clk;

	// Commands waiting to be offered, and the replies the walker still owes us, oldest first.
	walk_req_t   cmds_to_send[$];
	walk_reply_t replies_due[$];
	walk_req_t   cur_req;
	walk_reply_t oldest_reply;

	// Idle percentages per side; the stimulus process changes them between phases.
	int snd_idle_pct = 7;
	int rcv_idle_pct = 71;

	int errors = 0;
	int results_seen = 0;
	int out_hold_left = 0;
	int stall_cycles = 0;
	int status_tally[5] = '{default: 0};

	// Shadow of the walker's state: the whole table store and the bump counter.
	entry_t shadow_tbl[ENTRIES];
	int     shadow_next_page = 1;

	// Upper 27 address bits of a few table paths that most of the traffic reuses, so that
	// maps, translates and unmaps keep landing on the same leaves.
	logic [26:0] hot_paths[4];

	// Walks the shadow tables for one address, allocating missing tables when asked to.
	// On success leaf_slot is the store index of the leaf entry.
	function automatic status_t shadow_walk(input logic [GPA_W-1:0] gpa, input bit create,
			output int leaf_slot);
		int     page;
		int     pos;
		int     fresh;
		entry_t e;
		page = 0;
		leaf_slot = 0;
		for (int lvl = 0; lvl < 3; lvl++) begin
			pos = page * PAGE_ENTRIES + int'(gpa[47 - 9 * lvl -: 9]);
			e = shadow_tbl[pos];
			if (e[2:0] == 3'b000) begin
				if (!create)
					return ST_NO_ENTRY;
				// A failed allocation leaves any tables taken earlier in this walk in place.
				if (shadow_next_page >= TABLE_PAGES)
					return ST_NO_MEMORY;
				fresh = shadow_next_page;
				shadow_next_page++;
				for (int j = 0; j < PAGE_ENTRIES; j++)
					shadow_tbl[fresh * PAGE_ENTRIES + j] = '0;
				e = {20'(0), 32'(fresh), PTR_FLAGS};
				shadow_tbl[pos] = e;
			end
			page = (e[63:12] < TABLE_PAGES) ? int'(e[63:12]) : 0;
		end
		leaf_slot = page * PAGE_ENTRIES + int'(gpa[20:12]);
		return ST_OK;
	endfunction

	// Applies one accepted command to the shadow state and records the reply it must produce.
	task automatic predict_reply(input walk_req_t r);
		walk_reply_t rep;
		int          slot;
		entry_t      leaf;
		rep.st = ST_NO_ENTRY;
		rep.hpa = '0;
		slot = 0;
		if (r.cmd == CMD_XLATE) begin
			rep.st = shadow_walk(r.gpa, 1'b0, slot);
			if (rep.st == ST_OK) begin
				leaf = shadow_tbl[slot];
				if (leaf[2:0] == 3'b000)
					rep.st = ST_NOT_MAPPED;
				else
					rep.hpa = {leaf[51:12], r.gpa[11:0]};
			end
		end else if (r.cmd == CMD_MAP) begin
			rep.st = shadow_walk(r.gpa, r.create, slot);
			if (rep.st == ST_OK) begin
				if (!r.ovr && shadow_tbl[slot][2:0] != 3'b000)
					rep.st = ST_WOULD_OVERWRITE;
				else
					shadow_tbl[slot] = {12'(0), r.hpa[51:12], LEAF_FLAGS};
			end
		end else if (r.cmd == CMD_UNMAP) begin
			// Unmapping an absent leaf still succeeds and hands back a zero page.
			rep.st = shadow_walk(r.gpa, 1'b0, slot);
			if (rep.st == ST_OK) begin
				rep.hpa = {shadow_tbl[slot][51:12], 12'h000};
				shadow_tbl[slot] = '0;
			end
		end
		status_tally[int'(rep.st)]++;
		replies_due.push_back(rep);
	endtask

	task automatic queue_cmd(input logic [1:0] cmd, input logic [GPA_W-1:0] gpa,
			input logic [HPA_W-1:0] hpa, input bit create, input bit ovr);
		walk_req_t r;
		r.cmd = cmd;
		r.gpa = gpa;
		r.hpa = hpa;
		r.create = create;
		r.ovr = ovr;
		cmds_to_send.push_back(r);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// An address on one of the hot paths; the leaf index stays in a narrow window so that
	// hits are common, with the last slot of the page now and then.
	function automatic logic [GPA_W-1:0] hot_gpa();
		logic [8:0] leaf_idx;
		if ($urandom_range(99) < 10)
			leaf_idx = 9'h1FF;
		else
			leaf_idx = 9'($urandom_range(15));
		return {hot_paths[$urandom_range(3)], leaf_idx, 12'($urandom)};
	endfunction

	// Mostly traffic on the hot paths. About a quarter goes to fresh random addresses, mostly
	// maps with create, which keep eating table pages until the store runs out.
	task automatic queue_random_cmds(input int n);
		int         pick;
		bit         fresh_addr;
		logic [1:0] cmd;
		for (int i = 0; i < n; i++) begin
			fresh_addr = ($urandom_range(99) < 25);
			pick = $urandom_range(99);
			if (pick < 4)
				cmd = CMD_UNKNOWN;
			else if (pick < (fresh_addr ? 64 : 40))
				cmd = CMD_MAP;
			else if (pick < (fresh_addr ? 85 : 78))
				cmd = CMD_XLATE;
			else
				cmd = CMD_UNMAP;
			queue_cmd(cmd, fresh_addr ? GPA_W'(rand64()) : hot_gpa(), HPA_W'(rand64()),
				$urandom_range(99) < 80, 1'($urandom_range(1)));
		end
	endtask

	// Blocks until the driver has nothing left to offer and every reply has come back.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (cmds_to_send.size() != 0 || s_axis_tvalid || replies_due.size() != 0);
	endtask

	// Stream driver. On a handshake the item just taken goes to the predictor; a new item is
	// presented only when the slot is free, and a valid item is held until it is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				predict_reply(cur_req);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (cmds_to_send.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
					cur_req = cmds_to_send.pop_front();
					s_axis_tuser <= cur_req.cmd;
					s_axis_tdata <= {2'b00, cur_req.ovr, cur_req.create, cur_req.hpa,
						cur_req.gpa};
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Stream monitor. Every reply is checked against the oldest expectation; tready is then
	// chosen for the next cycle, with two long holds that let the walker back up.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (replies_due.size() == 0) begin
					$error("reply with no command outstanding: status %0d, result_hpa %h",
						m_axis_tuser, m_axis_tdata[51:0]);
					errors++;
				end else begin
					oldest_reply = replies_due.pop_front();
					if (m_axis_tuser !== oldest_reply.st) begin
						$error("status: expected %0d, got %0d", oldest_reply.st,
							m_axis_tuser);
						errors++;
					end
					if (m_axis_tdata[51:0] !== oldest_reply.hpa) begin
						$error("result_hpa: expected %h, got %h", oldest_reply.hpa,
							m_axis_tdata[51:0]);
						errors++;
					end
				end
				results_seen++;
				if (results_seen == 60 || results_seen == 350)
					out_hold_left = OUT_HOLD_CYCLES;
			end
			if (out_hold_left > 0) begin
				out_hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// Watchdog: any long stretch without a handshake on either side means the block hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
				if (stall_cycles >= WATCHDOG_LIMIT) begin
					$display("tb_top: watchdog expired after %0d idle cycles", stall_cycles);
					$display("tb_top: done, errors");
					$finish;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < ENTRIES; i++)
			shadow_tbl[i] = '0;
		hot_paths[0] = '0;
		hot_paths[1] = '1;
		hot_paths[2] = 27'($urandom);
		hot_paths[3] = 27'($urandom);

		// Directed opening on the all-zero path: every command against missing tables, then
		// building the path, overwrite rules, translate misses and unmap of an empty leaf.
		queue_cmd(CMD_XLATE, 48'h0, '1, 1'b1, 1'b1);
		queue_cmd(CMD_UNMAP, 48'h0, '1, 1'b1, 1'b1);
		queue_cmd(CMD_MAP, 48'h0, '1, 1'b0, 1'b1);
		queue_cmd(CMD_MAP, 48'h0, '1, 1'b1, 1'b0);
		queue_cmd(CMD_XLATE, 48'hFFF, '0, 1'b0, 1'b0);
		queue_cmd(CMD_MAP, 48'h0, 52'h12345_6789A_BCD, 1'b1, 1'b0);
		queue_cmd(CMD_MAP, 48'h0, 52'h0, 1'b0, 1'b1);
		queue_cmd(CMD_XLATE, 48'h123, '0, 1'b0, 1'b0);
		queue_cmd(CMD_MAP, 48'h0, 52'hABCDE_F0123_456, 1'b0, 1'b1);
		queue_cmd(CMD_XLATE, 48'h1000, '0, 1'b0, 1'b0);
		queue_cmd(CMD_UNMAP, 48'h1000, '0, 1'b0, 1'b0);
		queue_cmd(CMD_UNMAP, 48'h0, '0, 1'b0, 1'b0);
		queue_cmd(CMD_XLATE, 48'h0, '0, 1'b0, 1'b0);
		queue_cmd(CMD_UNKNOWN, '1, '1, 1'b1, 1'b1);
		queue_cmd(CMD_UNKNOWN, 48'h0, '0, 1'b0, 1'b0);
		// The all-ones path, then the two random hot paths.
		queue_cmd(CMD_MAP, '1, '1, 1'b1, 1'b1);
		queue_cmd(CMD_XLATE, '1, '0, 1'b0, 1'b0);
		queue_cmd(CMD_UNMAP, '1, '0, 1'b0, 1'b0);
		queue_cmd(CMD_MAP, {hot_paths[2], 21'h0}, HPA_W'(rand64()), 1'b1, 1'b0);
		queue_cmd(CMD_MAP, {hot_paths[3], 21'h0}, HPA_W'(rand64()), 1'b1, 1'b0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Phase one: sender rarely idles, receiver mostly does.
		queue_random_cmds(120);
		wait_drained();

		// Phase two after a full pause of the sender: roles of the two sides swapped.
		snd_idle_pct = 71;
		rcv_idle_pct = 7;
		queue_random_cmds(140);
		wait_drained();

		// Phase three: both sides at full rate.
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		queue_random_cmds(140);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("tb_top: %0d replies checked: ok %0d, no_entry %0d, no_memory %0d, %s %0d, %s %0d",
			results_seen, status_tally[ST_OK], status_tally[ST_NO_ENTRY],
			status_tally[ST_NO_MEMORY], "would_overwrite", status_tally[ST_WOULD_OVERWRITE],
			"not_mapped", status_tally[ST_NOT_MAPPED]);
		$display("tb_top: %0d of %0d table pages handed out; three idle mixes, two long holds",
			shadow_next_page, TABLE_PAGES);
		if (errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
